### design/ttlb_pkg.sv
// Shared types and constants for the tagged TLB with LRU replacement.
// Used by the controller, the datapath and the top level; no dependencies.
package ttlb_pkg;

  // Address split for 4 KiB pages
  localparam int PAGE_SHIFT  = 12;
  localparam int PAGE_BITS   = 20;
  localparam int STAMP_BITS  = 64;
  localparam int COUNT_BITS  = 32;
  localparam int LIMIT_BITS  = 5;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 96;

  // Operation codes carried on in_tuser
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // Register index taken from the APB word address
  localparam logic REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [LIMIT_BITS-1:0] ENTRIES_IN_USE_RESET = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic match;
    logic scan_read;
    logic evict;
    logic load_out;
  } ttlb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_fill;
    logic hit;
    logic room;
    logic scan_last;
    logic out_busy;
  } ttlb_status_t;

endpackage

### design/ttlb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/ttlb_ctrl.sv
// Controller state machine for the tagged TLB: sequences accept, tag match,
// LRU scan, eviction and result hand-off. Depends on ttlb_pkg.
module ttlb_ctrl import ttlb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  ttlb_status_t status,
  output ttlb_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_EVICT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next-state decode
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        if (status.is_fill && !status.hit && !status.room) state_nxt = S_SCAN;
        else state_nxt = S_FINISH;
      end
      S_SCAN: begin
        if (status.scan_last) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the current state
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.accept    = (state_r == S_IDLE) && in_tvalid;
    cmd.match     = (state_r == S_MATCH);
    cmd.scan_read = (state_r == S_SCAN);
    cmd.evict     = (state_r == S_EVICT);
    cmd.load_out  = (state_r == S_FINISH) && !status.out_busy;
  end

endmodule

### design/ttlb_datapath.sv
// Datapath for the tagged TLB: tag registers with parallel compare, frame and
// stamp RAMs, LRU scan, counters and the output register.
// Depends on ttlb_pkg and ttlb_ram.
module ttlb_datapath import ttlb_pkg::*; #(
  parameter int TLB_ENTRIES = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ttlb_cmd_t             cmd,
  output ttlb_status_t          status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic [LIMIT_BITS-1:0] entries_in_use,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);
  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

  // Latched input word
  logic                  op_r;
  logic [PID_BITS-1:0]   pid_r;
  logic [PAGE_BITS-1:0]  page_r;
  logic [PAGE_SHIFT-1:0] offset_r;
  logic [PAGE_BITS-1:0]  frame_in_r;

  logic [STAMP_BITS-1:0] time_r;
  logic [CNT_W-1:0]      valid_slots_r;
  logic                  hit_r;
  logic [COUNT_BITS-1:0] hits_r;
  logic [COUNT_BITS-1:0] misses_r;

  // Tag store, one compare cell per entry
  logic [PID_BITS-1:0]   tag_pid_r  [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]  tag_page_r [TLB_ENTRIES];

  // LRU scan state
  logic [IDX_W-1:0]      scan_addr_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  rd_live_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [STAMP_BITS-1:0] best_stamp_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  match_any;
  logic [IDX_W-1:0]      match_idx;
  logic [CNT_W-1:0]      limit;
  logic                  room;
  logic                  cand_better;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      append_idx;
  logic                  do_hit;
  logic                  do_append;
  logic                  tag_we;
  logic [IDX_W-1:0]      wr_idx;
  logic                  frame_we;
  logic                  stamp_we;
  logic [PAGE_BITS-1:0]  frame_rdata;
  logic [STAMP_BITS-1:0] stamp_rdata;
  logic                  lookup_hit;
  logic [COUNT_BITS-1:0] hits_nxt;
  logic [COUNT_BITS-1:0] misses_nxt;
  logic [COUNT_BITS-1:0] paddr;

  // Parallel tag compare; lowest matching valid entry wins
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < valid_slots_r) && (tag_pid_r[i] == pid_r) &&
          (tag_page_r[i] == page_r)) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  // Clamp the fill limit to 1..TLB_ENTRIES
  always_comb begin
    if (entries_in_use == '0) begin
      limit = CNT_W'(1);
    end else if (32'(entries_in_use) > TLB_ENTRIES) begin
      limit = CNT_W'(TLB_ENTRIES);
    end else begin
      limit = CNT_W'(entries_in_use);
    end
    room = (valid_slots_r < limit);
  end

  // Running minimum over stamps read back from the stamp RAM
  assign cand_better = rd_live_r && ((rd_idx_r == '0) || (stamp_rdata < best_stamp_r));
  assign victim_idx  = cand_better ? rd_idx_r : best_idx_r;
  assign append_idx  = IDX_W'(valid_slots_r);

  // Write decode for tags, frames and stamps
  always_comb begin
    do_hit    = cmd.match && match_any;
    do_append = cmd.match && (op_r == OP_FILL) && !match_any && room;
    tag_we    = do_append || cmd.evict;
    frame_we  = (do_hit && (op_r == OP_FILL)) || do_append || cmd.evict;
    stamp_we  = do_hit || do_append || cmd.evict;
    if (cmd.evict) wr_idx = victim_idx;
    else if (do_hit) wr_idx = match_idx;
    else wr_idx = append_idx;
  end

  ttlb_ram #(.WIDTH(PAGE_BITS), .DEPTH(TLB_ENTRIES)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (wr_idx),
    .wdata (frame_in_r),
    .re    (cmd.match),
    .raddr (match_idx),
    .rdata (frame_rdata)
  );

  ttlb_ram #(.WIDTH(STAMP_BITS), .DEPTH(TLB_ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (time_r),
    .re    (cmd.scan_read),
    .raddr (scan_addr_r),
    .rdata (stamp_rdata)
  );

  // Result word
  always_comb begin
    lookup_hit = (op_r == OP_LOOKUP) && hit_r;
    hits_nxt   = hits_r + COUNT_BITS'(lookup_hit);
    misses_nxt = misses_r + COUNT_BITS'((op_r == OP_LOOKUP) && !hit_r);
    paddr      = lookup_hit ? {frame_rdata, offset_r} : '0;
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_tuser;
      pid_r      <= PID_BITS'(in_tdata[7:0]);
      offset_r   <= in_tdata[8 +: PAGE_SHIFT];
      frame_in_r <= in_tdata[60 +: PAGE_BITS];
      if (in_tuser == OP_FILL) page_r <= in_tdata[40 +: PAGE_BITS];
      else page_r <= in_tdata[8 + PAGE_SHIFT +: PAGE_BITS];
    end
    if (cmd.match) begin
      hit_r <= match_any;
    end
  end

  // Tag store writes
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_pid_r[wr_idx]  <= pid_r;
      tag_page_r[wr_idx] <= page_r;
    end
  end

  // Advance the scan and track the least recently used entry
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_read) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
    end
    rd_idx_r <= scan_addr_r;
    if (cand_better) begin
      best_idx_r   <= rd_idx_r;
      best_stamp_r <= stamp_rdata;
    end
    if (cmd.load_out) begin
      out_hit_r  <= hit_r;
      out_data_r <= {misses_nxt, hits_nxt, paddr};
    end
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r        <= '0;
      valid_slots_r <= '0;
      hits_r        <= '0;
      misses_r      <= '0;
      rd_live_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_live_r <= cmd.scan_read;
      if (cmd.accept) time_r <= time_r + STAMP_BITS'(1);
      if (do_append) valid_slots_r <= valid_slots_r + CNT_W'(1);
      if (cmd.load_out) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.is_fill   = (op_r == OP_FILL);
    status.hit       = match_any;
    status.room      = room;
    status.scan_last = (scan_addr_r == IDX_W'(valid_slots_r - CNT_W'(1)));
    status.out_busy  = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  // Fill level never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(valid_slots_r) <= TLB_ENTRIES)
    else $error("valid slot count beyond table size");

  // Eviction only happens on a non-empty table
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> (valid_slots_r != '0))
    else $error("eviction with no valid slot");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_tready))
    else $error("output word overwritten");

  // Time advances by one per accepted word
  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (time_r == STAMP_BITS'($past(time_r) + STAMP_BITS'(1))))
    else $error("time counter did not advance");

endmodule

### design/tagged_tlb_lru_unit.sv
// Tagged fully associative TLB with LRU replacement, top level.
// A lookup, fill hit or fill append passes through the match and finish states to out_tvalid;
// a fill that must evict also reads one stamp per valid entry in the scan state, then evicts.
// One word is handled at a time: in_tready is high only in the idle state, and the LRU scan
// runs serially through the single stamp RAM read port; a stalled output holds the finish state.
// Reset (synchronous, rst_n low) empties the table, zeroes time and counters, sets limit 16.
module tagged_tlb_lru_unit import ttlb_pkg::*; #(
  parameter int TLB_ENTRIES = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pid[7:0], virtual_address[39:8], page_number[59:40], frame_number[79:60]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // physical_address[31:0], hit_count[63:32], miss_count[95:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // hit[0]
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  ttlb_cmd_t             cmd;
  ttlb_status_t          status;
  logic [LIMIT_BITS-1:0] entries_in_use_r;
  logic                  cfg_sel_limit;

  // Register file: one limit register at byte address 0
  assign cfg_pready    = 1'b1;
  assign cfg_sel_limit = (cfg_paddr[2] == REG_ENTRIES_IN_USE);
  assign cfg_prdata    = cfg_sel_limit ? 32'(entries_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= ENTRIES_IN_USE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_limit) begin
      entries_in_use_r <= cfg_pwdata[LIMIT_BITS-1:0];
    end
  end

  ttlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ttlb_datapath #(.TLB_ENTRIES(TLB_ENTRIES), .PID_BITS(PID_BITS)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .entries_in_use (entries_in_use_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser)
  );

endmodule
